### rtl/core/sdl_pkg.sv
package sdl_pkg;

    // Ring size and derived widths
    localparam int LED_COUNT   = 12;
    localparam int LED_W       = 6;
    localparam int X_W         = 20;
    localparam int Q_W         = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Angle to offset: offset = floor((tenths*2N + 3600) / 7200), via reciprocal
    localparam logic [X_W-1:0] HALF_STEP = X_W'(3600);
    localparam logic [X_W-1:0] ANG_MUL   = X_W'(2 * LED_COUNT);
    localparam logic [X_W-1:0] RECIP     = X_W'((64'd1 << 32) / 64'd7200 + 64'd1);
    localparam int             RECIP_SH  = 32;

    // Confidence clamp limits
    localparam logic [8:0] CONF_MIN = 9'd51;
    localparam logic [8:0] CONF_MAX = 9'd256;

    // Divide-by-three reciprocal for the distance-2 level
    localparam logic [7:0] THIRD_MUL = 8'd171;

    // Result word kinds
    typedef enum logic [1:0] {
        EV_PIXEL   = 2'd0,
        EV_RESTORE = 2'd1,
        EV_RESET   = 2'd2
    } t_event_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_LED  = 3'd0,
        CFG_CLOCKWISE  = 3'd1,
        CFG_HEAD_LEVEL = 3'd2,
        CFG_SIDE_LEVEL = 3'd3,
        CFG_INTERVAL   = 3'd4,
        CFG_IDLE_TMO   = 3'd5
    } t_cfg_reg;

    // Commands handed from front to back
    typedef enum logic [1:0] {
        CMD_RESET         = 2'd0,
        CMD_RESTORE_RESET = 2'd1,
        CMD_RESTORE       = 2'd2,
        CMD_REDRAW        = 2'd3
    } t_cmd_kind;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CALC1,
        BK_CALC2,
        BK_RUN,
        BK_EVENT
    } t_back_state;

    typedef struct packed {
        logic        show_enabled;
        logic        result_active;
        logic [11:0] angle_tenths;
        logic [8:0]  confidence_q8;
        logic [31:0] result_time_ms;
        logic [31:0] frame_time_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [LED_W-1:0] led_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [LED_W-1:0] front_led;
        logic             clockwise;
        logic [7:0]       head_level;
        logic [7:0]       side_level;
        logic [15:0]      update_interval_ms;
        logic [15:0]      idle_timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind      kind;
        logic [X_W-1:0] ang_x;
        logic [8:0]     conf;
    } t_cmd;

    // Small modulo-N table for narrow values
    typedef logic [LED_W-1:0] t_mod_tab [2**Q_W];

    function automatic t_mod_tab build_mod_tab();
        t_mod_tab tab;
        for (int k = 0; k < 2**Q_W; k++) begin
            tab[k] = LED_W'(k % LED_COUNT);
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = build_mod_tab();

endpackage

### rtl/core/sound_direction_led_ring.sv
// Channel  | Signals                                   | Moves
// ---------+-------------------------------------------+------------------------------
// in       | i_in_valid, o_in_ready, i_in_word         | one audio-frame word
// out      | o_out_valid, i_out_ready, o_out_word      | one pixel or event word
// cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index/data | one register write
//
// The front takes one input word per cycle while its four-entry command queue has room.
// A redraw runs through the back sequencer as a queue pop, two arithmetic steps, then
// one pixel per cycle while the output is free; a restore or reset pops, then sends
// one or two event words. Synchronous active-low reset clears tracking state, queue
// and sequencer, and loads the register defaults. A stalled output holds its word; the
// front keeps accepting until the queue fills.
module sound_direction_led_ring (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sdl_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sdl_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sdl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sdl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sdl_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_led          <= '0;
            r_cfg.clockwise          <= 1'b1;
            r_cfg.head_level         <= 8'd255;
            r_cfg.side_level         <= 8'd64;
            r_cfg.update_interval_ms <= 16'd100;
            r_cfg.idle_timeout_ms    <= 16'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FRONT_LED:  r_cfg.front_led          <= i_cfg_data[LED_W-1:0];
                CFG_CLOCKWISE:  r_cfg.clockwise          <= i_cfg_data[0];
                CFG_HEAD_LEVEL: r_cfg.head_level         <= i_cfg_data[7:0];
                CFG_SIDE_LEVEL: r_cfg.side_level         <= i_cfg_data[7:0];
                CFG_INTERVAL:   r_cfg.update_interval_ms <= i_cfg_data[15:0];
                CFG_IDLE_TMO:   r_cfg.idle_timeout_ms    <= i_cfg_data[15:0];
                default:        r_cfg                    <= r_cfg;
            endcase
        end
    end

    // front: accept and classify
    sdl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // command queue
    sdl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: word generation
    sdl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // a finder reset always closes its run
    a_reset_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.event_kind == EV_RESET) |-> o_out_word.last_of_run)
        else $error("reset word not last of run");

    // a pixel run ends exactly at the top ring index
    a_pixel_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.event_kind == EV_PIXEL) |->
        (o_out_word.last_of_run == (o_out_word.led_index == LED_W'(LED_COUNT - 1))))
        else $error("pixel run end mismatch");

    // a restore that is not last is followed at once by a reset
    a_restore_then_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_word.event_kind == EV_RESTORE &&
         !o_out_word.last_of_run) |=>
        (o_out_valid && o_out_word.event_kind == EV_RESET))
        else $error("restore not followed by reset");

    // queue never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("command queue overflow");

endmodule

### rtl/core/sdl_front.sv
module sdl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sdl_pkg::t_in_word i_in_word,
    input  sdl_pkg::t_cfg    i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output sdl_pkg::t_cmd    o_cmd
);
    import sdl_pkg::*;

    logic        r_ring_active;
    logic [31:0] r_last_source;
    logic [31:0] r_last_redraw;
    logic        n_ring_active;
    logic [31:0] n_last_source;
    logic [31:0] n_last_redraw;

    logic        accept;
    logic [31:0] since_redraw;
    logic [31:0] since_source;
    logic [8:0]  conf_clamped;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign since_redraw = i_in_word.frame_time_ms - r_last_redraw;
    assign since_source = i_in_word.frame_time_ms - r_last_source;

    // clamp confidence to its legal band
    always_comb begin
        if (i_in_word.confidence_q8 > CONF_MAX) begin
            conf_clamped = CONF_MAX;
        end else if (i_in_word.confidence_q8 < CONF_MIN) begin
            conf_clamped = CONF_MIN;
        end else begin
            conf_clamped = i_in_word.confidence_q8;
        end
    end

    // classify the word and update tracking state
    always_comb begin
        n_ring_active = r_ring_active;
        n_last_source = r_last_source;
        n_last_redraw = r_last_redraw;
        o_push        = 1'b0;
        o_cmd.kind    = CMD_RESET;
        o_cmd.ang_x   = X_W'(i_in_word.angle_tenths) * ANG_MUL + HALF_STEP;
        o_cmd.conf    = conf_clamped;
        if (accept) begin
            if (!i_in_word.show_enabled) begin
                o_push        = 1'b1;
                o_cmd.kind    = r_ring_active ? CMD_RESTORE_RESET : CMD_RESET;
                n_ring_active = 1'b0;
            end else if (i_in_word.result_active) begin
                n_ring_active = 1'b1;
                if (since_redraw >= {16'd0, i_cfg.update_interval_ms}) begin
                    o_push        = 1'b1;
                    o_cmd.kind    = CMD_REDRAW;
                    n_last_source = i_in_word.result_time_ms;
                    n_last_redraw = i_in_word.result_time_ms;
                end else begin
                    n_last_source = i_in_word.frame_time_ms;
                end
            end else if (r_ring_active &&
                         since_source >= {16'd0, i_cfg.idle_timeout_ms}) begin
                o_push        = 1'b1;
                o_cmd.kind    = CMD_RESTORE;
                n_ring_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_active <= 1'b0;
            r_last_source <= '0;
            r_last_redraw <= '0;
        end else begin
            r_ring_active <= n_ring_active;
            r_last_source <= n_last_source;
            r_last_redraw <= n_last_redraw;
        end
    end

endmodule

### rtl/core/sdl_queue.sv
module sdl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sdl_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output sdl_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import sdl_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/sdl_back.sv
module sdl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdl_pkg::t_cfg      i_cfg,
    input  logic               i_q_empty,
    input  sdl_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sdl_pkg::t_out_word o_out_word
);
    import sdl_pkg::*;

    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [Q_W-1:0]   r_q, n_q;
    logic [15:0]      r_hp, n_hp;
    logic [15:0]      r_sp, n_sp;
    logic [LED_W-1:0] r_head, n_head;
    logic [7:0]       r_hr, n_hr;
    logic [7:0]       r_hg, n_hg;
    logic [6:0]       r_s1, n_s1;
    logic [6:0]       r_s2, n_s2;
    logic [LED_W-1:0] r_idx, n_idx;
    logic             r_second, n_second;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic                  out_free;
    logic [2*X_W-1:0]      prod_full;
    logic [LED_W-1:0]      off;
    logic [LED_W-1:0]      front;
    logic [LED_W:0]        sum;
    logic [15:0]           third_prod;
    logic [LED_W:0]        fwd;
    logic [LED_W:0]        back_dist;
    logic [LED_W:0]        ring_dist;
    t_out_word             pix;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    // offset quotient and raw level products
    assign prod_full  = (2*X_W)'(r_cmd.ang_x) * (2*X_W)'(RECIP);
    assign off        = MOD_TAB[r_q];
    assign front      = MOD_TAB[Q_W'(i_cfg.front_led)];
    assign sum        = (LED_W+1)'(front) + (LED_W+1)'(off);
    assign third_prod = 16'(r_sp[15:8]) * 16'(THIRD_MUL);

    // ring distance of the current pixel from the head
    always_comb begin
        if (r_idx >= r_head) begin
            fwd = (LED_W+1)'(r_idx) - (LED_W+1)'(r_head);
        end else begin
            fwd = (LED_W+1)'(r_idx) + (LED_W+1)'(LED_COUNT) - (LED_W+1)'(r_head);
        end
        back_dist = (LED_W+1)'(LED_COUNT) - fwd;
        ring_dist = (fwd <= back_dist) ? fwd : back_dist;
    end

    // pixel word for the current index
    always_comb begin
        pix.event_kind  = EV_PIXEL;
        pix.led_index   = r_idx;
        pix.blue        = 8'd0;
        pix.last_of_run = (r_idx == LED_W'(LED_COUNT - 1));
        pix.red         = 8'd0;
        pix.green       = 8'd0;
        if (ring_dist == '0) begin
            pix.red   = r_hr;
            pix.green = r_hg;
        end else if (ring_dist == (LED_W+1)'(1)) begin
            pix.red   = {1'b0, r_s1};
            pix.green = {1'b0, r_s1};
        end else if (ring_dist == (LED_W+1)'(2)) begin
            pix.red   = {1'b0, r_s2};
            pix.green = {1'b0, r_s2};
        end
    end

    // sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_q         = r_q;
        n_hp        = r_hp;
        n_sp        = r_sp;
        n_head      = r_head;
        n_hr        = r_hr;
        n_hg        = r_hg;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_idx       = r_idx;
        n_second    = r_second;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_cmd;
                    n_second = 1'b0;
                    n_state  = (i_cmd.kind == CMD_REDRAW) ? BK_CALC1 : BK_EVENT;
                end
            end
            BK_CALC1: begin
                n_q     = prod_full[RECIP_SH+Q_W-1:RECIP_SH];
                n_hp    = 16'(i_cfg.head_level * r_cmd.conf);
                n_sp    = 16'(i_cfg.side_level * r_cmd.conf);
                n_state = BK_CALC2;
            end
            BK_CALC2: begin
                if (i_cfg.clockwise) begin
                    n_head = (sum >= (LED_W+1)'(LED_COUNT)) ?
                             LED_W'(sum - (LED_W+1)'(LED_COUNT)) : LED_W'(sum);
                end else if (front >= off) begin
                    n_head = front - off;
                end else begin
                    n_head = LED_W'((LED_W+1)'(front) + (LED_W+1)'(LED_COUNT)
                                    - (LED_W+1)'(off));
                end
                n_hr    = r_hp[15:8];
                n_hg    = r_sp[15:8];
                n_s1    = r_sp[15:9];
                n_s2    = third_prod[15:9];
                n_idx   = '0;
                n_state = BK_RUN;
            end
            BK_RUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = pix;
                    if (pix.last_of_run) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            BK_EVENT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_cmd.kind)
                        CMD_RESTORE: begin
                            n_out.event_kind  = EV_RESTORE;
                            n_out.last_of_run = 1'b1;
                            n_state           = BK_IDLE;
                        end
                        CMD_RESTORE_RESET: begin
                            if (!r_second) begin
                                n_out.event_kind = EV_RESTORE;
                                n_second         = 1'b1;
                            end else begin
                                n_out.event_kind  = EV_RESET;
                                n_out.last_of_run = 1'b1;
                                n_state           = BK_IDLE;
                            end
                        end
                        default: begin
                            n_out.event_kind  = EV_RESET;
                            n_out.last_of_run = 1'b1;
                            n_state           = BK_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
            r_idx       <= n_idx;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_q    <= n_q;
        r_hp   <= n_hp;
        r_sp   <= n_sp;
        r_head <= n_head;
        r_hr   <= n_hr;
        r_hg   <= n_hg;
        r_s1   <= n_s1;
        r_s2   <= n_s2;
        r_out  <= n_out;
    end

endmodule

### verif/sound_direction_led_ring_tb.sv
module sound_direction_led_ring_tb;

    import sdl_pkg::*;

    // Register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    localparam int IDLE_PCT      = 11;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = (QUEUE_DEPTH + 1) * (LED_COUNT + 3) + 8;

    logic clk;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Frames waiting to be offered, ring words still owed by the block
    t_in_word  frames_to_send[$];
    t_out_word ring_words_due[$];

    int frames_queued = 0;
    int frames_taken  = 0;
    int mismatches    = 0;

    // No random idling on either side while set
    logic calm = 1'b0;

    // Long output stall, counted in the monitor
    int   hold_left = 0;
    logic hold_done = 1'b0;

    // Shadow of the block's registers and tracking state
    t_cfg        ring_cfg;
    logic        ring_lit;
    logic [31:0] source_stamp;
    logic [31:0] redraw_stamp;

    logic [31:0] now_ms;

    sound_direction_led_ring u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Work out the ring words one frame causes and advance the shadow state
    function automatic void predict_ring_words(input t_in_word w);
        t_out_word   ow;
        int unsigned n;
        int unsigned off;
        int unsigned fl;
        int unsigned head;
        int unsigned fwd;
        int unsigned ring_dist;
        int unsigned c;
        logic [31:0] gap;
        n  = LED_COUNT;
        ow = '0;
        if (!w.show_enabled) begin
            if (ring_lit) begin
                ring_lit = 1'b0;
                ow.event_kind = EV_RESTORE;
                ring_words_due.push_back(ow);
            end
            ow.event_kind  = EV_RESET;
            ow.last_of_run = 1'b1;
            ring_words_due.push_back(ow);
            return;
        end
        if (w.result_active) begin
            gap = w.frame_time_ms - redraw_stamp;
            if (gap >= 32'(ring_cfg.update_interval_ms)) begin
                off  = ((32'(w.angle_tenths) * n * 2 + 3600) / 7200) % n;
                fl   = 32'(ring_cfg.front_led) % n;
                head = ring_cfg.clockwise ? (fl + off) % n : (fl + n - off) % n;
                c    = 32'(w.confidence_q8);
                if (c > 256) c = 256;
                if (c < 51) c = 51;
                for (int i = 0; i < n; i++) begin
                    fwd       = (i + n - head) % n;
                    ring_dist = (fwd <= n - fwd) ? fwd : n - fwd;
                    ow = '0;
                    ow.event_kind = EV_PIXEL;
                    ow.led_index  = LED_W'(i);
                    if (ring_dist == 0) begin
                        ow.red   = 8'(32'(ring_cfg.head_level) * c / 256);
                        ow.green = 8'(32'(ring_cfg.side_level) * c / 256);
                    end else if (ring_dist == 1) begin
                        ow.red   = 8'(32'(ring_cfg.side_level) * c / 512);
                        ow.green = ow.red;
                    end else if (ring_dist == 2) begin
                        ow.red   = 8'(32'(ring_cfg.side_level) * c / 768);
                        ow.green = ow.red;
                    end
                    ow.last_of_run = (i == n - 1);
                    ring_words_due.push_back(ow);
                end
                ring_lit     = 1'b1;
                source_stamp = w.result_time_ms;
                redraw_stamp = w.result_time_ms;
            end else begin
                ring_lit     = 1'b1;
                source_stamp = w.frame_time_ms;
            end
        end else begin
            gap = w.frame_time_ms - source_stamp;
            if (ring_lit && gap >= 32'(ring_cfg.idle_timeout_ms)) begin
                ring_lit = 1'b0;
                ow.event_kind  = EV_RESTORE;
                ow.last_of_run = 1'b1;
                ring_words_due.push_back(ow);
            end
        end
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Driver: offer queued frames, predict each one as it is taken
    always @(posedge clk) begin : drive_frames
        logic     offer;
        t_in_word next_word;
        offer     = in_valid;
        next_word = in_word;
        if (!rst_n) begin
            offer = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_ring_words(in_word);
                frames_taken <= frames_taken + 1;
                offer = 1'b0;
            end
            if (!offer && frames_to_send.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_word = frames_to_send.pop_front();
                offer     = 1'b1;
            end
        end
        in_valid <= offer;
        in_word  <= next_word;
    end

    // Monitor: compare each taken word with the oldest one owed, then pick ready
    always @(posedge clk) begin : watch_ring
        t_out_word want;
        logic      take;
        if (rst_n && out_valid && out_ready) begin
            if (ring_words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, out_word);
                mismatches++;
            end else begin
                want = ring_words_due.pop_front();
                check_field("event_kind", want.event_kind, out_word.event_kind);
                check_field("led_index", want.led_index, out_word.led_index);
                check_field("red", want.red, out_word.red);
                check_field("green", want.green, out_word.green);
                check_field("blue", want.blue, out_word.blue);
                check_field("last_of_run", want.last_of_run, out_word.last_of_run);
            end
        end
        if (!rst_n) begin
            take = 1'b0;
        end else if (hold_left != 0) begin
            take = 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && frames_taken >= HOLD_AT) begin
            take = 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            take = calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
        out_ready <= take;
    end

    // One register write, shadow follows the block's masking
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRONT_LED:  ring_cfg.front_led          = data[LED_W-1:0];
            CFG_CLOCKWISE:  ring_cfg.clockwise          = data[0];
            CFG_HEAD_LEVEL: ring_cfg.head_level         = data[7:0];
            CFG_SIDE_LEVEL: ring_cfg.side_level         = data[7:0];
            CFG_INTERVAL:   ring_cfg.update_interval_ms = data;
            CFG_IDLE_TMO:   ring_cfg.idle_timeout_ms    = data;
            default: ;
        endcase
    endtask

    task automatic set_ring_config(input logic [15:0] front, input logic [15:0] cw,
                                   input logic [15:0] head, input logic [15:0] side,
                                   input logic [15:0] interval, input logic [15:0] tmo);
        write_reg(CFG_FRONT_LED, front);
        write_reg(CFG_CLOCKWISE, cw);
        write_reg(CFG_HEAD_LEVEL, head);
        write_reg(CFG_SIDE_LEVEL, side);
        write_reg(CFG_INTERVAL, interval);
        write_reg(CFG_IDLE_TMO, tmo);
    endtask

    task automatic queue_frame(input logic show, input logic act, input logic [11:0] angle,
                               input logic [8:0] conf, input logic [31:0] rtime,
                               input logic [31:0] ftime);
        t_in_word w;
        w.show_enabled   = show;
        w.result_active  = act;
        w.angle_tenths   = angle;
        w.confidence_q8  = conf;
        w.result_time_ms = rtime;
        w.frame_time_ms  = ftime;
        frames_to_send.push_back(w);
        frames_queued++;
    endtask

    // Mostly a running frame clock with plausible results, some noise
    task automatic queue_random_frames(input int count);
        int unsigned roll;
        int unsigned step;
        logic        act;
        logic [11:0] angle;
        logic [8:0]  conf;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                now_ms = $urandom;
                queue_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            12'($urandom_range(0, 4095)), 9'($urandom_range(0, 511)),
                            $urandom, now_ms);
            end else if (roll < 14) begin
                now_ms = now_ms + $urandom_range(0, 50);
                queue_frame(1'b0, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                            9'($urandom_range(0, 511)), now_ms, now_ms);
            end else begin
                if ($urandom_range(0, 99) < 10)
                    step = 32'(ring_cfg.idle_timeout_ms) + $urandom_range(0, 40);
                else
                    step = $urandom_range(0, 32'(ring_cfg.update_interval_ms) + 20);
                now_ms = now_ms + step;
                act    = $urandom_range(0, 99) < 70;
                angle  = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, 3599))
                                                      : 12'($urandom_range(0, 4095));
                conf   = ($urandom_range(0, 99) < 80) ? 9'($urandom_range(51, 256))
                                                      : 9'($urandom_range(0, 511));
                queue_frame(1'b1, act, angle, conf, now_ms - $urandom_range(0, 8), now_ms);
            end
        end
    endtask

    // Everything offered, taken and answered, plus a tail for silent frames
    task automatic wait_ring_idle();
        while (frames_taken != frames_queued || ring_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        ring_cfg.front_led          = 6'd0;
        ring_cfg.clockwise          = 1'b1;
        ring_cfg.head_level         = 8'd255;
        ring_cfg.side_level         = 8'd64;
        ring_cfg.update_interval_ms = 16'd100;
        ring_cfg.idle_timeout_ms    = 16'd1000;
        ring_lit     = 1'b0;
        source_stamp = '0;
        redraw_stamp = '0;
        now_ms       = 32'd2000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under reset defaults
        queue_frame(0, 0, 0, 0, 0, 0);                      // disabled, ring dark
        queue_frame(1, 1, 0, 256, 100, 100);                // first redraw
        queue_frame(1, 1, 1800, 128, 150, 150);             // inside interval
        queue_frame(1, 0, 0, 0, 0, 500);                    // idle, not timed out
        queue_frame(1, 0, 0, 0, 0, 1150);                   // idle timeout
        queue_frame(1, 0, 0, 0, 0, 1200);                   // idle, ring already off
        queue_frame(1, 1, 3599, 0, 1300, 1300);             // top angle, low conf clamp
        queue_frame(1, 1, 4095, 511, 1400, 1400);           // angle past range, high clamp
        queue_frame(1, 1, 150, 50, 1500, 1500);             // half step rounds up
        queue_frame(1, 1, 149, 257, 1600, 1600);            // just under half step
        queue_frame(0, 1, 900, 256, 1650, 1650);            // disable while lit
        queue_frame(0, 1, 0, 0, 0, 0);                      // disable again
        queue_frame(1, 1, 2700, 200, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
        queue_frame(1, 1, 2700, 200, 32'h50, 32'h50);       // wrapped, inside interval
        queue_frame(1, 1, 300, 100, 32'h70, 32'h80);        // wrapped, redraw
        queue_frame(1, 0, 0, 0, 0, 32'h70 + 999);
        queue_frame(1, 0, 0, 0, 0, 32'h70 + 1000);          // timeout on the boundary
        queue_frame(1, 1, 1234, 300, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_ring_idle();

        // Defaults, long output stall happens in here
        queue_random_frames(80);
        wait_ring_idle();

        // Low extremes: front past ring size, counter-clockwise, zero interval and timeout
        set_ring_config(16'd63, 16'd0, 16'd0, 16'd255, 16'd0, 16'd0);
        queue_random_frames(80);
        wait_ring_idle();

        // High extremes for head level, interval and timeout, junk in the upper data bits, near the time wrap
        write_reg(CFG_SPARE_IDX, 16'hFFFF);
        set_ring_config(16'hFFC5, 16'hFFFF, 16'hFFFF, 16'hFF00, 16'hFFFF, 16'hFFFF);
        now_ms = 32'hFFFF_0000;
        queue_random_frames(80);
        wait_ring_idle();

        // Random setting, no idling on either side
        set_ring_config(16'($urandom_range(0, 63)), 16'($urandom_range(0, 1)),
                        16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                        16'($urandom_range(0, 400)), 16'($urandom_range(0, 3000)));
        @(posedge clk);
        calm <= 1'b1;
        queue_random_frames(80);
        wait_ring_idle();
        calm <= 1'b0;

        // Random setting, sender pauses halfway until all words are back
        set_ring_config(16'($urandom_range(0, 63)), 16'($urandom_range(0, 1)),
                        16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                        16'($urandom_range(0, 400)), 16'($urandom_range(0, 3000)));
        queue_random_frames(40);
        wait_ring_idle();
        queue_random_frames(40);
        wait_ring_idle();

        // Random setting over the full register ranges
        set_ring_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        queue_random_frames(80);
        wait_ring_idle();

        if (mismatches == 0 && ring_words_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
